### rtl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types and constants for the fraction arithmetic / gcd reduce block.
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int OUT_W             = 34;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // product slots, in the order the multiplier produces them
  typedef enum logic [1:0] {
    PR_LN_RD = 2'd0,
    PR_RN_LD = 2'd1,
    PR_LD_RD = 2'd2,
    PR_LN_RN = 2'd3
  } prod_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_GCD,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic  load;
    logic  mul_en;
    prod_e mul_sel;
    logic  comb;
    logic  gcd_step;
    logic  div_init;
    logic  div_step;
    logic  finish;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic gcd_eq;
  } sts_t;

endpackage

### rtl/fra_ctrl.sv
// ----------------------------------------------------------------------------
// fra_ctrl
// Sequencer: product phase, combine, binary gcd, quotient phase, write-back.
// ----------------------------------------------------------------------------
module fra_ctrl #(
  parameter int OPERAND_WIDTH = fra_pkg::OPERAND_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  output fra_pkg::cmd_t cmd_o,
  input  fra_pkg::sts_t sts_i
);
  import fra_pkg::*;

  localparam int VW    = 2 * OPERAND_WIDTH + 1;
  localparam int CNT_W = $clog2(VW);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= cmd_o.finish;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (start) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(3)) begin
          state_d = ST_COMB;
        end
      end
      ST_COMB: begin
        state_d = ST_GCD;
      end
      ST_GCD: begin
        cnt_d = '0;
        if (sts_i.zero) begin
          state_d = ST_DONE;
        end else if (sts_i.gcd_eq) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(VW - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = prod_e'(cnt_q[1:0]);
    case (state_q)
      ST_IDLE: cmd_o.load   = start;
      ST_MUL:  cmd_o.mul_en = 1'b1;
      ST_COMB: cmd_o.comb   = 1'b1;
      ST_GCD: begin
        if (!sts_i.zero) begin
          cmd_o.div_init = sts_i.gcd_eq;
          cmd_o.gcd_step = !sts_i.gcd_eq;
        end
      end
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_DONE: cmd_o.finish   = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

### rtl/fra_dp.sv
// ----------------------------------------------------------------------------
// fra_dp
// Datapath: shared multiplier, combine, binary gcd and two restoring dividers.
// ----------------------------------------------------------------------------
module fra_dp #(
  parameter int OPERAND_WIDTH = fra_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  fra_pkg::cmd_t                    cmd_i,
  output fra_pkg::sts_t                    sts_o,
  input  logic [1:0]                       req_type_i,
  input  logic signed [OPERAND_WIDTH-1:0]  left_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]  left_den_i,
  input  logic signed [OPERAND_WIDTH-1:0]  right_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]  right_den_i,
  output logic signed [fra_pkg::OUT_W-1:0] raw_num_o,
  output logic signed [fra_pkg::OUT_W-1:0] raw_den_o,
  output logic signed [fra_pkg::OUT_W-1:0] red_num_o,
  output logic signed [fra_pkg::OUT_W-1:0] red_den_o
);
  import fra_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int VW = 2 * W + 1;

  op_e                 op_q;
  logic signed [W-1:0] ln_q, ld_q, rn_q, rd_q;
  logic signed [PW-1:0] p_q [4];

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;

  logic signed [VW-1:0] num_c, den_c;
  logic signed [VW-1:0] num_q, den_q;
  logic                 zero_q;

  logic [VW-1:0] a_q, b_q, n_q, d_q;
  logic [VW-1:0] rem_n_q, rem_d_q;
  logic [VW:0]   sh_n, sh_d;
  logic          q_n, q_d;

  logic signed [VW-1:0] red_num_c, red_den_c;

  logic signed [OUT_W-1:0] raw_num_q, raw_den_q, red_num_q, red_den_q;

  always_comb begin
    case (cmd_i.mul_sel)
      PR_LN_RD: begin mul_a = ln_q; mul_b = rd_q; end
      PR_RN_LD: begin mul_a = rn_q; mul_b = ld_q; end
      PR_LD_RD: begin mul_a = ld_q; mul_b = rd_q; end
      PR_LN_RN: begin mul_a = ln_q; mul_b = rn_q; end
      default:  begin mul_a = ln_q; mul_b = rd_q; end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    den_c = VW'(p_q[PR_LD_RD]);
    case (op_q)
      OP_ADD: num_c = VW'(p_q[PR_LN_RD]) + VW'(p_q[PR_RN_LD]);
      OP_SUB: num_c = VW'(p_q[PR_LN_RD]) - VW'(p_q[PR_RN_LD]);
      OP_MUL: num_c = VW'(p_q[PR_LN_RN]);
      OP_DIV: begin
        num_c = VW'(p_q[PR_LN_RD]);
        den_c = VW'(p_q[PR_RN_LD]);
      end
      default: num_c = VW'(p_q[PR_LN_RD]);
    endcase
  end

  // restoring division of n and d by the odd gcd part, one quotient bit a cycle
  assign sh_n = {rem_n_q, n_q[VW-1]};
  assign sh_d = {rem_d_q, d_q[VW-1]};
  assign q_n  = (sh_n >= {1'b0, a_q});
  assign q_d  = (sh_d >= {1'b0, a_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_e'(req_type_i);
      ln_q <= left_num_i;
      ld_q <= left_den_i;
      rn_q <= right_num_i;
      rd_q <= right_den_i;
    end
    if (cmd_i.mul_en) begin
      p_q[cmd_i.mul_sel] <= prod;
    end
    if (cmd_i.comb) begin
      num_q  <= num_c;
      den_q  <= den_c;
      zero_q <= (num_c == '0) || (den_c == '0);
      a_q    <= num_c[VW-1] ? $unsigned(-num_c) : $unsigned(num_c);
      b_q    <= den_c[VW-1] ? $unsigned(-den_c) : $unsigned(den_c);
      n_q    <= num_c[VW-1] ? $unsigned(-num_c) : $unsigned(num_c);
      d_q    <= den_c[VW-1] ? $unsigned(-den_c) : $unsigned(den_c);
    end
    if (cmd_i.gcd_step) begin
      // common factor of two is divided out of the operands right away
      if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        n_q <= n_q >> 1;
        d_q <= d_q >> 1;
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q > b_q) begin
        a_q <= (a_q - b_q) >> 1;
      end else begin
        b_q <= (b_q - a_q) >> 1;
      end
    end
    if (cmd_i.div_init) begin
      rem_n_q <= '0;
      rem_d_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_n_q <= q_n ? VW'(sh_n - {1'b0, a_q}) : sh_n[VW-1:0];
      rem_d_q <= q_d ? VW'(sh_d - {1'b0, a_q}) : sh_d[VW-1:0];
      n_q     <= {n_q[VW-2:0], q_n};
      d_q     <= {d_q[VW-2:0], q_d};
    end
    if (cmd_i.finish) begin
      raw_num_q <= OUT_W'(num_q);
      raw_den_q <= OUT_W'(den_q);
      red_num_q <= OUT_W'(red_num_c);
      red_den_q <= OUT_W'(red_den_c);
    end
  end

  assign red_num_c = zero_q ? num_q : (num_q[VW-1] ? -$signed(n_q) : $signed(n_q));
  assign red_den_c = zero_q ? den_q : (den_q[VW-1] ? -$signed(d_q) : $signed(d_q));

  assign sts_o.zero   = zero_q;
  assign sts_o.gcd_eq = (a_q == b_q);

  assign raw_num_o = raw_num_q;
  assign raw_den_o = raw_den_q;
  assign red_num_o = red_num_q;
  assign red_den_o = red_den_q;

endmodule

### rtl/fraction_arith_reduce.sv
// ----------------------------------------------------------------------------
// fraction_arith_reduce
// Signed fraction add/sub/mul/div with gcd reduction of the result.
//
//   channel   | handshake              | word
//   ----------+------------------------+--------------------------------------
//   request   | start (in), busy (out) | req_type_i, left/right num/den _i
//   result    | done_o (1-cycle pulse) | raw_num_o, raw_den_o, red_num_o,
//             |                        | red_den_o
//
// A request word is taken on a clock edge with start high and busy low.
// Four products go through one shared multiplier, then a combine step forms
// the raw pair. If either raw value is zero, the gcd and quotient phases are
// skipped. Otherwise a binary gcd runs until both magnitudes agree, and the
// quotient phase then divides both magnitudes by their gcd.
// Reset returns the sequencer to idle.
// The result cannot be stalled; it is held on the ports until the next one.
// ----------------------------------------------------------------------------
module fraction_arith_reduce #(
  parameter int OPERAND_WIDTH = fra_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       req_type_i,
  input  logic signed [OPERAND_WIDTH-1:0]  left_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]  left_den_i,
  input  logic signed [OPERAND_WIDTH-1:0]  right_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]  right_den_i,
  output logic                             done_o,
  output logic signed [fra_pkg::OUT_W-1:0] raw_num_o,
  output logic signed [fra_pkg::OUT_W-1:0] raw_den_o,
  output logic signed [fra_pkg::OUT_W-1:0] red_num_o,
  output logic signed [fra_pkg::OUT_W-1:0] red_den_o
);
  import fra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fra_ctrl #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .cmd_o (cmd),
    .sts_i (sts)
  );

  fra_dp #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_type_i (req_type_i),
    .left_num_i (left_num_i),
    .left_den_i (left_den_i),
    .right_num_i(right_num_i),
    .right_den_i(right_den_i),
    .raw_num_o  (raw_num_o),
    .raw_den_o  (raw_den_o),
    .red_num_o  (red_num_o),
    .red_den_o  (red_den_o)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("accepted word did not start a run");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a run is active");

  a_div_after_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_init |-> sts.gcd_eq && !sts.zero)
    else $error("quotient phase started before gcd settled");

  a_finish_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> done_o && !busy)
    else $error("write-back not followed by result strobe");
`endif

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for fraction_arith_reduce. A queue of request words
// (directed corner cases, then random fractions biased toward small values,
// extremes and scaled powers of two) feeds a start/busy driver with random
// gaps. A monitor compares every done_o word against a predictor that forms
// the cross products and the gcd-reduced pair, with signs kept per value.
// ----------------------------------------------------------------------------
module tb_top;
  import fra_pkg::*;

  localparam int OP_W      = OPERAND_WIDTH_DEF;
  localparam int CYC_LIMIT = 1_000_000;
  localparam int DRAIN_CYC = 120;

  typedef logic signed [OP_W-1:0]  opnd_t;
  typedef logic signed [OUT_W-1:0] wide_t;

  typedef struct {
    op_e   op;
    opnd_t ln;
    opnd_t ld;
    opnd_t rn;
    opnd_t rd;
    int    gap;
    bit    hold;
  } frac_req_t;

  typedef struct {
    wide_t raw_num;
    wide_t raw_den;
    wide_t red_num;
    wide_t red_den;
  } frac_res_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  start       = 1'b0;
  logic  [1:0] req_type_i = '0;
  opnd_t left_num_i  = '0;
  opnd_t left_den_i  = '0;
  opnd_t right_num_i = '0;
  opnd_t right_den_i = '0;
  logic  busy;
  logic  done_o;
  wide_t raw_num_o;
  wide_t raw_den_o;
  wide_t red_num_o;
  wide_t red_den_o;

  frac_req_t pending_reqs[$];
  frac_res_t expected_fracs[$];
  frac_req_t cur_req;
  int        gap_cnt   = 0;
  int        err_cnt   = 0;
  int        cycle_cnt = 0;
  bit        burst     = 1'b0;

  fraction_arith_reduce #(
    .OPERAND_WIDTH(OP_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_type_i (req_type_i),
    .left_num_i (left_num_i),
    .left_den_i (left_den_i),
    .right_num_i(right_num_i),
    .right_den_i(right_den_i),
    .done_o     (done_o),
    .raw_num_o  (raw_num_o),
    .raw_den_o  (raw_den_o),
    .red_num_o  (red_num_o),
    .red_den_o  (red_den_o)
  );

  always #1 clk_i = ~clk_i;

  // cross products, then magnitudes divided by their gcd unless a value is zero
  function automatic frac_res_t reduce_frac(frac_req_t r);
    longint a;
    longint b;
    longint c;
    longint d;
    longint num;
    longint den;
    longint qn;
    longint qd;
    longint unsigned mn;
    longint unsigned md;
    longint unsigned g;
    longint unsigned x;
    longint unsigned t;
    frac_res_t res;
    a = r.ln;
    b = r.ld;
    c = r.rn;
    d = r.rd;
    case (r.op)
      OP_ADD: begin
        num = a * d + c * b;
        den = b * d;
      end
      OP_SUB: begin
        num = a * d - c * b;
        den = b * d;
      end
      OP_MUL: begin
        num = a * c;
        den = b * d;
      end
      default: begin
        num = a * d;
        den = c * b;
      end
    endcase
    qn = num;
    qd = den;
    if (num != 0 && den != 0) begin
      mn = (num < 0) ? -num : num;
      md = (den < 0) ? -den : den;
      g  = mn;
      x  = md;
      while (x != 0) begin
        t = g % x;
        g = x;
        x = t;
      end
      qn = longint'(mn / g);
      qd = longint'(md / g);
      if (num < 0) qn = -qn;
      if (den < 0) qd = -qd;
    end
    res.raw_num = num[OUT_W-1:0];
    res.raw_den = den[OUT_W-1:0];
    res.red_num = qn[OUT_W-1:0];
    res.red_den = qd[OUT_W-1:0];
    return res;
  endfunction

  task automatic queue_req(op_e op, int ln, int ld, int rn, int rd, bit hold);
    frac_req_t r;
    r.op   = op;
    r.ln   = opnd_t'(ln);
    r.ld   = opnd_t'(ld);
    r.rn   = opnd_t'(rn);
    r.rd   = opnd_t'(rd);
    r.gap  = burst ? 0 : int'($urandom_range(0, 10));
    r.hold = hold;
    pending_reqs.push_back(r);
  endtask

  function automatic int rand_opnd();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 4))
          0: return -32768;
          1: return 32767;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      1, 2, 3: return int'($urandom_range(0, 40)) - 20;
      4, 5: return (int'($urandom_range(0, 14)) - 7) << $urandom_range(0, 12);
      default: return int'($urandom);
    endcase
  endfunction

  function automatic bit field_ok(string name, wide_t expv, wide_t actv);
    if (expv !== actv) begin
      $error("%s: expected %0d, actual %0d", name, expv, actv);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_start;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        expected_fracs.push_back(reduce_frac(cur_req));
        nxt_start = 1'b0;
        gap_cnt   = (pending_reqs.size() > 0) ? pending_reqs[0].gap : 0;
      end
      if (!nxt_start) begin
        if (gap_cnt > 0) begin
          if (!busy) begin
            gap_cnt--;
          end
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].hold && expected_fracs.size() > 0)) begin
          cur_req = pending_reqs.pop_front();
          req_type_i  <= cur_req.op;
          left_num_i  <= cur_req.ln;
          left_den_i  <= cur_req.ld;
          right_num_i <= cur_req.rn;
          right_den_i <= cur_req.rd;
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    frac_res_t e;
    if (rst_ni && done_o) begin
      if (expected_fracs.size() == 0) begin
        $error("result word with no request outstanding");
        err_cnt++;
      end else begin
        e = expected_fracs.pop_front();
        if (!field_ok("raw_num", e.raw_num, raw_num_o)) err_cnt++;
        if (!field_ok("raw_den", e.raw_den, raw_den_o)) err_cnt++;
        if (!field_ok("red_num", e.red_num, red_num_o)) err_cnt++;
        if (!field_ok("red_den", e.red_den, red_den_o)) err_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYC_LIMIT) begin
      $display("fraction_arith_reduce test failed");
      $finish;
    end
  end

  initial begin
    // directed words
    queue_req(OP_ADD, 1, 2, 1, 3, 1'b0);
    queue_req(OP_SUB, 1, 2, 1, 2, 1'b0);
    queue_req(OP_MUL, 0, 5, 3, 7, 1'b0);
    queue_req(OP_DIV, 3, 4, 0, 5, 1'b0);
    queue_req(OP_ADD, 1, 0, 1, 0, 1'b0);
    queue_req(OP_MUL, 32767, 32767, 32767, 32767, 1'b0);
    queue_req(OP_MUL, -32768, -32768, -32768, -32768, 1'b0);
    queue_req(OP_ADD, -32768, 32767, -32768, 32767, 1'b0);
    queue_req(OP_SUB, 32767, -32768, -32768, 32767, 1'b0);
    queue_req(OP_DIV, -32768, 1, 1, -32768, 1'b0);
    queue_req(OP_DIV, -1, -1, -1, -1, 1'b0);
    queue_req(OP_ADD, 6, 4, 10, 8, 1'b0);
    queue_req(OP_SUB, -3, 5, 2, -7, 1'b0);
    queue_req(OP_MUL, 4096, -2048, -1024, 512, 1'b0);
    queue_req(OP_DIV, 12, 18, -8, 27, 1'b0);
    queue_req(OP_ADD, 0, 0, 0, 0, 1'b1);
    queue_req(OP_MUL, 32767, 1, -32768, 1, 1'b0);
    queue_req(OP_SUB, 1, 1, -1, 1, 1'b0);
    queue_req(OP_SUB, -32768, -32768, 32767, 32767, 1'b0);
    queue_req(OP_DIV, 32767, -32768, 32767, -32768, 1'b0);
    queue_req(OP_ADD, 21845, -21846, -21846, 21845, 1'b0);
    queue_req(OP_MUL, 0, 0, 5, 9, 1'b0);
    // random words, with zero-gap bursts and a few full drains
    for (int i = 0; i < 1800; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      queue_req(op_e'($urandom_range(0, 3)), rand_opnd(), rand_opnd(),
                rand_opnd(), rand_opnd(), (i % 250 == 125));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || start) @(posedge clk_i);
    while (expected_fracs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("fraction_arith_reduce test passed");
    end else begin
      $display("fraction_arith_reduce test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/fra_pkg.sv
rtl/fra_ctrl.sv
rtl/fra_dp.sv
rtl/fraction_arith_reduce.sv
verif/tb_top.sv
